### rtl/lprd_pkg.sv
// Shared types and constants for the length-prefixed record deframer.
package lprd_pkg;

    // Header codes with special meaning
    localparam logic [15:0] LEN_END  = 16'hFFFF;
    localparam logic [15:0] LEN_NULL = 16'hFFFE;
    localparam logic [7:0]  NEWLINE  = 8'd10;

    // Result buffer depth: one transaction yields at most two results
    localparam int unsigned MAX_RESULTS = 2;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        PH_HDR_HI = 3'd0,
        PH_HDR_LO = 3'd1,
        PH_DATA   = 3'd2,
        PH_PAD    = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_record;
        logic       truncated;
        logic       last;
    } t_result;

    // Results produced by one decode step
    typedef struct packed {
        logic [CNT_W-1:0] count;
        t_result          res0;
        t_result          res1;
    } t_decode;

endpackage

### rtl/lprd_decode.sv
// Framing state machine: turns one stream byte into zero, one or two results.
module lprd_decode import lprd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_stream,
    output t_decode    o_dec
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_header_high, n_header_high;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic        r_needs_pad, n_needs_pad;

    logic [15:0] w_len;
    logic [15:0] w_left_m1;

    assign w_len     = {r_header_high, i_data_byte};
    assign w_left_m1 = r_bytes_left - 16'd1;

    // Hold framing state; advance only when a transaction is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR_HI;
            r_header_high <= '0;
            r_bytes_left  <= '0;
            r_needs_pad   <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_header_high <= n_header_high;
            r_bytes_left  <= n_bytes_left;
            r_needs_pad   <= n_needs_pad;
        end
    end

    // Next state and results for the byte at the input
    always_comb begin
        n_phase       = r_phase;
        n_header_high = r_header_high;
        n_bytes_left  = r_bytes_left;
        n_needs_pad   = r_needs_pad;
        o_dec         = '0;

        case (r_phase)
            PH_HDR_HI: begin
                if (i_end_of_stream) begin
                    n_phase = PH_DONE;
                end else begin
                    n_header_high = i_data_byte;
                    n_phase       = PH_HDR_LO;
                end
            end
            PH_HDR_LO: begin
                if (i_end_of_stream || w_len == LEN_END) begin
                    n_phase = PH_DONE;
                end else if (w_len == LEN_NULL) begin
                    n_phase = PH_HDR_HI;
                end else if (w_len == 16'd0) begin
                    // empty record: newline only
                    o_dec.count = CNT_W'(1);
                    o_dec.res0  = '{out_char: NEWLINE, end_of_record: 1'b1,
                                    truncated: 1'b0, last: 1'b1};
                    n_phase     = PH_HDR_HI;
                end else begin
                    n_bytes_left = w_len;
                    n_needs_pad  = w_len[0];
                    n_phase      = PH_DATA;
                end
            end
            PH_DATA: begin
                if (i_end_of_stream) begin
                    // cut short: truncated newline, then stop
                    o_dec.count = CNT_W'(1);
                    o_dec.res0  = '{out_char: NEWLINE, end_of_record: 1'b1,
                                    truncated: 1'b1, last: 1'b1};
                    n_phase     = PH_DONE;
                end else begin
                    n_bytes_left = w_left_m1;
                    if (w_left_m1 != 16'd0) begin
                        o_dec.count = CNT_W'(1);
                        o_dec.res0  = '{out_char: i_data_byte, end_of_record: 1'b0,
                                        truncated: 1'b0, last: 1'b1};
                    end else begin
                        // final data byte, then the closing newline
                        o_dec.count = CNT_W'(2);
                        o_dec.res0  = '{out_char: i_data_byte, end_of_record: 1'b0,
                                        truncated: 1'b0, last: 1'b0};
                        o_dec.res1  = '{out_char: NEWLINE, end_of_record: 1'b1,
                                        truncated: 1'b0, last: 1'b1};
                        n_phase     = r_needs_pad ? PH_PAD : PH_HDR_HI;
                    end
                end
            end
            PH_PAD: begin
                // drop the pad byte
                n_phase = i_end_of_stream ? PH_DONE : PH_HDR_HI;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

endmodule

### rtl/lprd_out_buf.sv
// Two-entry result buffer that presents decoded results one per transaction.
module lprd_out_buf import lprd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_decode i_dec,
    input  logic    i_out_ready,
    output logic    o_space,
    output logic    o_out_valid,
    output t_result o_res
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_result          r_slot0, n_slot0;
    t_result          r_slot1, n_slot1;
    logic             w_pop;

    assign w_pop       = (r_cnt != '0) && i_out_ready;
    assign o_out_valid = (r_cnt != '0);
    assign o_res       = r_slot0;
    // Buffer is empty after this cycle's pop
    assign o_space     = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_out_ready);

    // Pop the head, shift, then load a new decode into the emptied buffer
    always_comb begin
        n_cnt   = r_cnt - CNT_W'(w_pop);
        n_slot0 = w_pop ? r_slot1 : r_slot0;
        n_slot1 = r_slot1;
        if (i_push) begin
            n_cnt   = i_dec.count;
            n_slot0 = i_dec.res0;
            n_slot1 = i_dec.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

### rtl/length_prefixed_record_deframer_unit.sv
// Top level of the length-prefixed record deframer.
//
// Input channel (i_in_valid / o_in_ready) carries one stream byte per
// transaction, or an end mark when i_end_of_stream is high. Output channel
// (o_out_valid / i_out_ready) carries one result per transaction: a data
// byte or the end-of-record newline, with its flags; o_last marks the final
// result caused by an input byte.
// An accepted byte is held in an input register, decoded once the result
// buffer has space and written into a two-entry result register, from which
// its first result goes to the output. One byte is taken every cycle
// while each byte gives at most one result and the receiver keeps up; a byte
// that closes a record gives two results, which leave the output one after
// the other. The result buffer sets the rate: it takes a decoded byte only
// when it will be empty at the end of the cycle.
// Reset clears the framing state back to waiting for a header and drops
// any byte or result in flight. When the receiver stalls, results hold in
// the buffer and o_in_ready falls once the input register is occupied.
// After the end code or an end mark the block swallows all input until reset.
module length_prefixed_record_deframer_unit import lprd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_stream,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_end_of_record,
    output logic       o_truncated,
    output logic       o_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;
    logic       w_space;
    logic       w_step;
    t_decode    w_dec;
    t_result    w_res;

    assign w_step     = r_in_valid && w_space;
    assign o_in_ready = !r_in_valid || w_step;

    // Input register: load on accept, release when decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    lprd_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_data_byte     (r_in_byte),
        .i_end_of_stream (r_in_eos),
        .o_dec           (w_dec)
    );

    lprd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_step),
        .i_dec       (w_dec),
        .i_out_ready (i_out_ready),
        .o_space     (w_space),
        .o_out_valid (o_out_valid),
        .o_res       (w_res)
    );

    assign o_out_char      = w_res.out_char;
    assign o_end_of_record = w_res.end_of_record;
    assign o_truncated     = w_res.truncated;
    assign o_last          = w_res.last;

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the length-prefixed record deframer: directed and random record streams.
module tb_top;
    import lprd_pkg::*;

    // Ways the stream can be closed; only one per run since reset is applied once
    typedef enum logic [2:0] {
        ENDING_LEN_CODE,
        ENDING_EOS_HDR_HI,
        ENDING_EOS_HDR_LO,
        ENDING_EOS_DATA,
        ENDING_EOS_PAD
    } t_ending;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_data = 8'h00;
    logic       in_eos = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_char;
    logic       out_eor;
    logic       out_trunc;
    logic       out_last;

    // Decoder state mirrored by the testbench
    t_phase      dec_phase = PH_HDR_HI;
    logic [7:0]  hdr_high = 8'h00;
    logic [15:0] bytes_remaining = 16'h0000;
    logic        odd_len = 1'b0;
    t_result     expected_chars[$];

    int unsigned burst_left = 0;
    int unsigned items_accepted = 0;
    int unsigned records_sent = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;
    t_ending     ending;

    int unsigned stall_span = 0;
    logic [1:0]  stall_mode = 2'd0;

    length_prefixed_record_deframer_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_data_byte     (in_data),
        .i_end_of_stream (in_eos),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_out_char      (out_char),
        .o_end_of_record (out_eor),
        .o_truncated     (out_trunc),
        .o_last          (out_last)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort after 50 ms, well above the slowest legal run
    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic t_result mk_char(input logic [7:0] ch, input logic eor,
                                        input logic trunc, input logic lst);
        t_result r;
        r.out_char      = ch;
        r.end_of_record = eor;
        r.truncated     = trunc;
        r.last          = lst;
        return r;
    endfunction

    // Advance the mirrored decoder by one accepted transaction, queue its results
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        logic [15:0] len;
        len = {hdr_high, b};
        case (dec_phase)
            PH_HDR_HI: begin
                if (eos) begin
                    dec_phase = PH_DONE;
                end else begin
                    hdr_high  = b;
                    dec_phase = PH_HDR_LO;
                end
            end
            PH_HDR_LO: begin
                if (eos || len == LEN_END) begin
                    dec_phase = PH_DONE;
                end else if (len == LEN_NULL) begin
                    dec_phase = PH_HDR_HI;
                end else if (len == 16'h0000) begin
                    expected_chars.push_back(mk_char(NEWLINE, 1'b1, 1'b0, 1'b1));
                    dec_phase = PH_HDR_HI;
                end else begin
                    bytes_remaining = len;
                    odd_len         = len[0];
                    dec_phase       = PH_DATA;
                end
            end
            PH_DATA: begin
                if (eos) begin
                    expected_chars.push_back(mk_char(NEWLINE, 1'b1, 1'b1, 1'b1));
                    dec_phase = PH_DONE;
                end else begin
                    bytes_remaining = bytes_remaining - 16'd1;
                    if (bytes_remaining != 16'h0000) begin
                        expected_chars.push_back(mk_char(b, 1'b0, 1'b0, 1'b1));
                    end else begin
                        expected_chars.push_back(mk_char(b, 1'b0, 1'b0, 1'b0));
                        expected_chars.push_back(mk_char(NEWLINE, 1'b1, 1'b0, 1'b1));
                        dec_phase = odd_len ? PH_PAD : PH_HDR_HI;
                    end
                end
            end
            PH_PAD: begin
                dec_phase = eos ? PH_DONE : PH_HDR_HI;
            end
            default: begin
                dec_phase = PH_DONE;
            end
        endcase
    endtask

    // Drive one transaction; insert a random gap between bursts
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= b;
        in_eos   <= eos;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_accepted++;
        decode_byte(b, eos);
    endtask

    // Hold off the sender until every queued result has been seen
    task automatic wait_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0) @(posedge clk);
        burst_left = 0;
    endtask

    // Header, random payload, and a pad byte for odd lengths
    task automatic send_record(input logic [15:0] rec_len);
        int unsigned idx;
        send_byte(rec_len[15:8], 1'b0);
        send_byte(rec_len[7:0], 1'b0);
        if (rec_len != LEN_NULL && rec_len != LEN_END) begin
            for (idx = 0; idx < rec_len; idx++)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            if (rec_len[0])
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        records_sent++;
    endtask

    task automatic test_directed_framing;
        // zero length: newline only
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        // null record: no output
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFE, 1'b0);
        // length one: byte, newline, then a discarded pad
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // length two with the newline code inside the data
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(NEWLINE, 1'b0);
        // length three, mid-range bytes and a pad
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        records_sent += 5;
    endtask

    // Length above one byte: the counter borrows across its high byte
    task automatic test_long_record;
        send_record(16'h0101);
    endtask

    task automatic test_random_records;
        int unsigned start_count;
        int unsigned pick;
        logic [15:0] rec_len;
        start_count = items_accepted;
        while (items_accepted - start_count < 500) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                rec_len = 16'h0000;
            else if (pick < 15)
                rec_len = LEN_NULL;
            else if (pick < 70)
                rec_len = 16'($urandom_range(1, 8));
            else if (pick < 93)
                rec_len = 16'($urandom_range(9, 64));
            else
                rec_len = 16'($urandom_range(65, 300));
            send_record(rec_len);
            if ($urandom_range(0, 49) == 0)
                wait_drained;
        end
    endtask

    // Close the stream one of several ways, then feed transactions that must be dropped
    task automatic test_stream_ending;
        int unsigned len;
        int unsigned cut;
        int unsigned idx;
        ending = t_ending'($urandom_range(0, 4));
        case (ending)
            ENDING_LEN_CODE: begin
                send_byte(LEN_END[15:8], 1'b0);
                send_byte(LEN_END[7:0], 1'b0);
            end
            ENDING_EOS_HDR_HI: begin
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            ENDING_EOS_HDR_LO: begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            ENDING_EOS_DATA: begin
                len = $urandom_range(1, 6);
                cut = $urandom_range(0, len - 1);
                send_byte(8'h00, 1'b0);
                send_byte(8'(len), 1'b0);
                for (idx = 0; idx < cut; idx++)
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                len = 2 * $urandom_range(0, 3) + 1;
                send_byte(8'h00, 1'b0);
                send_byte(8'(len), 1'b0);
                for (idx = 0; idx < len; idx++)
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        repeat (12) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Receiver: switch between stall patterns in random stretches
    always @(posedge clk) begin
        if (stall_span == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_span <= $urandom_range(8, 64);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: out_ready <= ~out_ready;
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each accepted result with the oldest expected one
    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n && $isunknown(out_valid))
            report_mismatch("output valid is unknown");
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            results_checked++;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected result char %02h", out_char));
            end else begin
                want = expected_chars.pop_front();
                if (out_char !== want.out_char)
                    report_mismatch($sformatf("char got %02h want %02h",
                                              out_char, want.out_char));
                if (out_eor !== want.end_of_record)
                    report_mismatch($sformatf("end_of_record got %b want %b",
                                              out_eor, want.end_of_record));
                if (out_trunc !== want.truncated)
                    report_mismatch($sformatf("truncated got %b want %b",
                                              out_trunc, want.truncated));
                if (out_last !== want.last)
                    report_mismatch($sformatf("last got %b want %b",
                                              out_last, want.last));
            end
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_framing;
        wait_drained;
        test_long_record;
        wait_drained;
        test_random_records;
        test_stream_ending;
        wait_drained;
        repeat (10) @(posedge clk);

        $display("Run: %0d bytes accepted over %0d records, %0d results checked",
                 items_accepted, records_sent, results_checked);
        $display("Stream closed via %s, %0d mismatches", ending.name(), mismatch_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/lprd_pkg.sv
rtl/lprd_decode.sv
rtl/lprd_out_buf.sv
rtl/length_prefixed_record_deframer_unit.sv
bench/tb_top.sv
